// ----- rtl/assert_macros.svh -----
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error("assertion failed: invariant violated");
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(lbl, ck, rn, expr)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/cscan_pkg.sv -----
// Shared constants and types of the C-SCAN disk scheduler.
`timescale 1ns / 1ps
package cscan_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int TRACK_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_REQUESTS);
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int SEEK_W       = 22;
    localparam int DISK_W       = TRACK_BITS + 1;
    localparam int CFG_W        = DISK_W;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_TRACKS = 1'b1;

    localparam logic [SEEK_W-1:0] SEEK_MAX  = {SEEK_W{1'b1}};
    localparam logic [DISK_W-1:0] DISK_FULL = DISK_W'(1) << TRACK_BITS;

    typedef logic [TRACK_BITS-1:0] track_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        track_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ----- rtl/cscan_if.sv -----
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface cscan_req_if import cscan_pkg::*; ;
    logic   valid;
    logic   ready;
    track_t request_track;
    logic   last_request;

    modport source (output valid, output request_track, output last_request, input ready);
    modport sink (input valid, input request_track, input last_request, output ready);
endinterface

interface cscan_res_if import cscan_pkg::*; ;
    logic              valid;
    logic              ready;
    track_t            served_track;
    logic              is_edge;
    logic [SEEK_W-1:0] total_seek;
    logic              last_result;

    modport source (output valid, output served_track, output is_edge, output total_seek,
                    output last_result, input ready);
    modport sink (input valid, input served_track, input is_edge, input total_seek,
                  input last_result, output ready);
endinterface

// ----- rtl/cscan_store_ram.sv -----
// Request store: one write port, one registered read port.
`timescale 1ns / 1ps
module cscan_store_ram import cscan_pkg::*;
(
    input  logic     clk,
    input  ram_req_t ram_req,
    output track_t   rdata
);

    track_t store_mem [MAX_REQUESTS];
    track_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            store_mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re)
        begin
            rdata_reg <= store_mem[ram_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cscan_disk_scheduler_unit.sv -----
// C-SCAN disk scheduler top level: sorted request store and sweep sequencer.
//
//  channel | dir | handshake       | word
//  req     | in  | valid/ready     | request_track, last_request
//  res     | out | valid/ready     | served_track, is_edge, total_seek, last_result
//  cfg     | in  | cfg_we          | cfg_index, cfg_wdata (start_head, disk_tracks)
//
// Insert: a request moves each larger entry up one place, one RAM read/write per shift;
//   into an empty store it is written directly, and a full store drops it.
// Last request: split search reads each entry below start_head (S_SPLIT_RD, S_SPLIT_CHK),
//   then each result word is read and sent (S_EMIT_RD, S_EMIT_OUT).
// Reset clears control state only; unwritten store entries are never read.
// req.ready is high only between items; a stalled result holds the sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cscan_disk_scheduler_unit import cscan_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cscan_req_if.sink            req,
    cscan_res_if.source          res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS       = 3'd1;
    localparam logic [2:0] S_INS_PUT   = 3'd2;
    localparam logic [2:0] S_SPLIT_RD  = 3'd3;
    localparam logic [2:0] S_SPLIT_CHK = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_OUT  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  split_reg, split_next;
    logic              phase_reg, phase_next;
    logic              src_edge_reg, src_edge_next;
    track_t            head_reg, head_next;
    logic [SEEK_W-1:0] seek_reg, seek_next;
    logic              out_valid_reg, out_valid_next;

    track_t            req_track_reg;
    logic              req_last_reg;
    track_t            out_track_reg;
    logic              out_edge_reg;
    logic [SEEK_W-1:0] out_seek_reg;
    logic              out_last_reg;

    track_t            start_head_reg;
    logic [DISK_W-1:0] disk_tracks_reg;

    ram_req_t          ram_req;
    track_t            rdata;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              out_last;
    logic              in_sweep;
    track_t            emit_track;
    track_t            seek_step;
    logic [SEEK_W:0]   seek_sum;
    logic [SEEK_W-1:0] seek_sat;
    logic [DISK_W-1:0] tracks_m1;
    track_t            edge_track;
    logic              full;

    cscan_store_ram u_store
    (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_head_reg  <= '0;
            disk_tracks_reg <= DISK_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_HEAD:  start_head_reg  <= cfg_wdata[TRACK_BITS-1:0];
                CFG_DISK_TRACKS: disk_tracks_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign tracks_m1 = disk_tracks_reg - DISK_W'(1);
    assign edge_track = (disk_tracks_reg == '0) ? '0 :
                        (disk_tracks_reg > DISK_FULL) ? '1 : tracks_m1[TRACK_BITS-1:0];

    assign full      = (count_reg == CNT_W'(MAX_REQUESTS));
    assign in_accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign in_sweep  = (state_reg == S_EMIT_RD) || (state_reg == S_EMIT_OUT);

    assign emit_track = src_edge_reg ? edge_track : rdata;
    assign seek_step  = (emit_track >= head_reg) ? emit_track - head_reg
                                                 : head_reg - emit_track;
    assign seek_sum   = {1'b0, seek_reg} + (SEEK_W + 1)'(seek_step);
    assign seek_sat   = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];
    assign out_last   = src_edge_reg ? (split_reg == '0)
                                     : (phase_reg && (idx_reg + CNT_W'(1) == split_reg));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        split_next    = split_reg;
        phase_next    = phase_reg;
        src_edge_next = src_edge_reg;
        head_next     = head_reg;
        seek_next     = seek_reg;
        out_load      = 1'b0;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next = '0;
                    if (full)
                    begin
                        state_next = req.last_request ? S_SPLIT_RD : S_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = '0;
                        ram_req.wdata = req.request_track;
                        count_next    = CNT_W'(1);
                        state_next    = req.last_request ? S_SPLIT_RD : S_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                        idx_next      = count_reg;
                        state_next    = S_INS;
                    end
                end
            end
            S_INS:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[ADDR_W-1:0];
                if (rdata > req_track_reg)
                begin
                    ram_req.wdata = rdata;
                    if (idx_reg == CNT_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_W'(idx_reg - CNT_W'(2));
                        idx_next      = idx_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    ram_req.wdata = req_track_reg;
                    count_next    = count_reg + CNT_W'(1);
                    idx_next      = '0;
                    state_next    = req_last_reg ? S_SPLIT_RD : S_IDLE;
                end
            end
            S_INS_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = req_track_reg;
                count_next    = count_reg + CNT_W'(1);
                idx_next      = '0;
                state_next    = req_last_reg ? S_SPLIT_RD : S_IDLE;
            end
            S_SPLIT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    split_next = idx_reg;
                    phase_next = 1'b0;
                    head_next  = start_head_reg;
                    seek_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[ADDR_W-1:0];
                    state_next    = S_SPLIT_CHK;
                end
            end
            S_SPLIT_CHK:
            begin
                if (rdata < start_head_reg)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SPLIT_RD;
                end
                else
                begin
                    split_next = idx_reg;
                    phase_next = 1'b0;
                    head_next  = start_head_reg;
                    seek_next  = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                // upper pass ends at the edge visit
                if (!phase_reg && (idx_reg == count_reg))
                begin
                    src_edge_next = 1'b1;
                end
                else
                begin
                    src_edge_next = 1'b0;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[ADDR_W-1:0];
                end
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    seek_next = seek_sat;
                    head_next = emit_track;
                    if (src_edge_reg)
                    begin
                        phase_next = 1'b1;
                        idx_next   = '0;
                        head_next  = '0;   // wrap to track 0, jump not counted
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    if (out_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            split_reg     <= '0;
            phase_reg     <= 1'b0;
            src_edge_reg  <= 1'b0;
            head_reg      <= '0;
            seek_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            split_reg     <= split_next;
            phase_reg     <= phase_next;
            src_edge_reg  <= src_edge_next;
            head_reg      <= head_next;
            seek_reg      <= seek_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_track_reg <= req.request_track;
            req_last_reg  <= req.last_request;
        end
        if (out_load)
        begin
            out_track_reg <= emit_track;
            out_edge_reg  <= src_edge_reg;
            out_seek_reg  <= seek_sat;
            out_last_reg  <= out_last;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.served_track = out_track_reg;
    assign res.is_edge      = out_edge_reg;
    assign res.total_seek   = out_seek_reg;
    assign res.last_result  = out_last_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_REQUESTS))
    `ASSERT_IMPLIES(a_write_in_range, clk, rst_n, ram_req.we, CNT_W'(ram_req.waddr) <= count_reg)
    `ASSERT_IMPLIES(a_split_bound, clk, rst_n, in_sweep, split_reg <= count_reg)
    `ASSERT_NEXT(a_done_clears, clk, rst_n, out_load && out_last, state_reg == S_IDLE && count_reg == '0)

endmodule

// ----- bench/tb_cscan_disk_scheduler_unit.sv -----
// Self-checking testbench for the C-SCAN disk scheduler: directed rows, then random batches.
`timescale 1ns / 1ps
module tb_cscan_disk_scheduler_unit import cscan_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 360;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic                  last;
        logic                  typed;
        track_t                exp_track;
        logic                  exp_edge;
        logic [SEEK_W-1:0]     exp_seek;
    } stim_row_t;

    typedef struct packed {
        track_t                track;
        logic                  is_edge;
        logic [SEEK_W-1:0]     seek;
        logic                  fin;
    } visit_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    cscan_req_if req_ch ();
    cscan_res_if res_ch ();

    cscan_disk_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // scheduler mirror
    track_t        sorted_tracks [$];
    visit_t        pending_visits [$];
    logic [15:0]   head_cfg;
    logic [16:0]   tracks_cfg;
    track_t        arm_track;
    int unsigned   seek_acc;

    int            error_count;
    int            cycle_count;
    int            burst_left;
    int            sink_mode;
    int            sink_left;
    visit_t        got_visit;

    stim_row_t directed_rows [17] = '{
        '{ROW_REQ, CFG_START_HEAD,  17'd0,      1'b1, 1'b1, 16'd65535, 1'b1, 22'd65535},
        '{ROW_CFG, CFG_START_HEAD,  17'd100,    1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_CFG, CFG_DISK_TRACKS, 17'd1000,   1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd50,     1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd200,    1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd100,    1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd20,     1'b1, 1'b1, 16'd50,    1'b0, 22'd949},
        '{ROW_CFG, CFG_START_HEAD,  17'd0,      1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_CFG, CFG_DISK_TRACKS, 17'd0,      1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd65535,  1'b1, 1'b1, 16'd0,     1'b1, 22'd131070},
        '{ROW_CFG, CFG_DISK_TRACKS, 17'd131071, 1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_CFG, CFG_START_HEAD,  17'd65535,  1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd65535,  1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd0,      1'b1, 1'b1, 16'd0,     1'b0, 22'd0},
        '{ROW_CFG, CFG_START_HEAD,  17'h19C40,  1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd7,      1'b0, 1'b0, 16'd0,     1'b0, 22'd0},
        '{ROW_REQ, CFG_START_HEAD,  17'd7,      1'b1, 1'b1, 16'd7,     1'b0, 22'd25542}
    };

    function automatic void log_visit(track_t trk, logic edge_flag, logic fin);
        int unsigned step_len;
        step_len = (trk >= arm_track) ? int'(trk) - int'(arm_track)
                                      : int'(arm_track) - int'(trk);
        seek_acc = seek_acc + step_len;
        if (seek_acc > SEEK_MAX)
            seek_acc = SEEK_MAX;
        arm_track = trk;
        pending_visits.push_back('{trk, edge_flag, seek_acc[SEEK_W-1:0], fin});
    endfunction

    function automatic void take_request(track_t trk, logic fin);
        int          pos;
        int          split;
        int unsigned span;
        track_t      edge_trk;
        track_t      head;
        if (sorted_tracks.size() < MAX_REQUESTS)
        begin
            pos = sorted_tracks.size();
            while (pos > 0 && sorted_tracks[pos-1] > trk)
                pos--;
            sorted_tracks.insert(pos, trk);
        end
        if (!fin)
            return;
        span = tracks_cfg;
        if (span < 1)
            span = 1;
        if (span > (1 << TRACK_BITS))
            span = 1 << TRACK_BITS;
        edge_trk = track_t'(span - 1);
        head = head_cfg;
        split = 0;
        while (split < sorted_tracks.size() && sorted_tracks[split] < head)
            split++;
        arm_track = head;
        seek_acc = 0;
        for (int i = split; i < sorted_tracks.size(); i++)
            log_visit(sorted_tracks[i], 1'b0, 1'b0);
        log_visit(edge_trk, 1'b1, split == 0);
        arm_track = '0;
        for (int i = 0; i < split; i++)
            log_visit(sorted_tracks[i], 1'b0, i + 1 == split);
        sorted_tracks.delete();
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_req(track_t trk, logic fin);
        pace();
        req_ch.valid         <= 1'b1;
        req_ch.request_track <= trk;
        req_ch.last_request  <= fin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        take_request(trk, fin);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_visits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == CFG_START_HEAD)
            head_cfg = data[15:0];
        else
            tracks_cfg = data[16:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: long ready runs, hard stalls and random ready levels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_mode = 0;
            sink_left = 0;
        end
        else
        begin
            if (sink_left == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                sink_left = (sink_mode == 1) ? $urandom_range(1, 16) : $urandom_range(8, 40);
            end
            sink_left--;
            case (sink_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'b0;
                default: res_ch.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_visits.size() == 0)
            begin
                $error("unexpected result word: served_track %0d", res_ch.served_track);
                error_count++;
            end
            else
            begin
                got_visit = pending_visits.pop_front();
                if (res_ch.served_track !== got_visit.track)
                begin
                    $error("served_track: expected %0d, actual %0d",
                           got_visit.track, res_ch.served_track);
                    error_count++;
                end
                if (res_ch.is_edge !== got_visit.is_edge)
                begin
                    $error("is_edge: expected %0d, actual %0d", got_visit.is_edge, res_ch.is_edge);
                    error_count++;
                end
                if (res_ch.total_seek !== got_visit.seek)
                begin
                    $error("total_seek: expected %0d, actual %0d",
                           got_visit.seek, res_ch.total_seek);
                    error_count++;
                end
                if (res_ch.last_result !== got_visit.fin)
                begin
                    $error("last_result: expected %0d, actual %0d",
                           got_visit.fin, res_ch.last_result);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        items_done;
        int        batch_no;
        int        batch_len;
        int        pick;
        track_t    trk;
        track_t    prev_trk;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_START_HEAD;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.request_track <= '0;
        req_ch.last_request  <= 1'b0;
        head_cfg    = '0;
        tracks_cfg  = 17'd65536;
        arm_track   = '0;
        seek_acc    = 0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        items_done  = 0;
        batch_no    = 0;
        prev_trk    = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_cfg(row.idx, row.data);
            end
            else
            begin
                send_req(row.data[TRACK_BITS-1:0], row.last);
                if (row.last && row.typed)
                    pending_visits[pending_visits.size()-1] =
                        '{row.exp_track, row.exp_edge, row.exp_seek, 1'b1};
            end
        end

        while (items_done < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 7);
            if (batch_no == 0 || pick < 2)
            begin
                settle();
                case ($urandom_range(0, 4))
                    0:       write_cfg(CFG_START_HEAD, 17'd0);
                    1:       write_cfg(CFG_START_HEAD, 17'd65535);
                    2:       write_cfg(CFG_START_HEAD, {1'b1, 16'($urandom_range(0, 65535))});
                    default: write_cfg(CFG_START_HEAD, 17'($urandom_range(0, 65535)));
                endcase
                case ($urandom_range(0, 5))
                    0:       write_cfg(CFG_DISK_TRACKS, 17'd0);
                    1:       write_cfg(CFG_DISK_TRACKS, 17'd1);
                    2:       write_cfg(CFG_DISK_TRACKS, 17'd65536);
                    3:       write_cfg(CFG_DISK_TRACKS, 17'd131071);
                    4:       write_cfg(CFG_DISK_TRACKS, 17'($urandom_range(2, 300)));
                    default: write_cfg(CFG_DISK_TRACKS, 17'($urandom_range(1, 65536)));
                endcase
            end
            else if (pick == 2)
                settle();

            // first batch and an occasional later one overfill the store
            batch_len = (batch_no == 0 || $urandom_range(0, 7) == 0) ?
                        $urandom_range(33, 40) : $urandom_range(1, 8);
            for (int i = 0; i < batch_len; i++)
            begin
                case ($urandom_range(0, 6))
                    0:       trk = '0;
                    1:       trk = '1;
                    2:       trk = head_cfg + track_t'($urandom_range(0, 15)) - track_t'(8);
                    3:       trk = prev_trk;
                    default: trk = track_t'($urandom_range(0, 65535));
                endcase
                prev_trk = trk;
                if (sorted_tracks.size() < MAX_REQUESTS)
                    items_done++;
                send_req(trk, i == batch_len - 1);
            end
            batch_no++;
        end

        settle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
